@@ design/lst_pkg.sv @@
// Shared types and constants for the lost sequence tracker.
// Holds the command codes and the packed input and result words.
// No dependencies.
`default_nettype none

package lst_pkg;

    localparam int SEQ_W  = 32;
    localparam int WIN_W  = 32;
    localparam int NOW_W  = 48;
    localparam int OUT_W  = 9;
    localparam int CMD_W  = 3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd5000;

    localparam logic [CMD_W-1:0] CMD_ADD_ONE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_RANGE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AGE_ONLY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;

    // One command word.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SEQ_W-1:0] seq_num;
        logic [SEQ_W-1:0] range_end;
        logic [NOW_W-1:0] now_time;
    } t_item;

    // One result word.
    typedef struct packed {
        logic             overflow;
        logic [OUT_W-1:0] lost_total;
        logic [OUT_W-1:0] longest_run;
        logic [OUT_W-1:0] mean_run;
    } t_result;

endpackage

`default_nettype wire

@@ design/lost_sequence_tracker_unit.sv @@
// Lost sequence tracker: sorted table of lost numbers with expiry, held in one RAM.
// Each table walk reads an entry from the RAM and then uses it; an insert
// or remove walks to the position and shifts the tail, aging walks the expired prefix
// and shifts the rest, a query walks all entries and then divides the count by the runs.
// An add range repeats the insert walk per number. One command is in work at a time.
// Reset (synchronous, active low) empties the table; the receiver cannot stall results.
`default_nettype none

module lost_sequence_tracker_unit
    import lst_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int TIME_BITS   = 48
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  wire t_item       i_item,
    input  wire              i_cfg_we,
    input  wire [WIN_W-1:0]  i_cfg_wdata,
    output logic             o_valid,
    output t_result          o_result
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int DC_W  = $clog2(CNT_W + 1);
    localparam int MW    = SEQ_W + TIME_BITS;
    localparam int SUM_W = ((TIME_BITS > WIN_W) ? TIME_BITS : WIN_W) + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    typedef enum logic [4:0] {
        S_IDLE, S_FIND_RD, S_FIND_CK, S_FOUND, S_UP_RD, S_UP_WR, S_INS_DONE,
        S_CNT_RD, S_CNT_CK, S_DN_RD, S_DN_WR, S_AGE, S_AGE_RD, S_AGE_CK,
        S_Q_RD, S_Q_CK, S_DIV, S_FINISH
    } t_state;

    t_state               r_state;
    logic [CMD_W-1:0]     r_op;
    logic [SEQ_W-1:0]     r_key;
    logic [SEQ_W-1:0]     r_end;
    logic [TIME_BITS-1:0] r_now;
    logic [WIN_W-1:0]     r_window;
    logic [CNT_W-1:0]     r_count;
    logic [TIME_BITS-1:0] r_oldest;
    logic [CNT_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_off;
    logic [CNT_W-1:0]     r_present;
    logic                 r_match;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_runs;
    logic [CNT_W-1:0]     r_len;
    logic [CNT_W-1:0]     r_longest;
    logic [SEQ_W-1:0]     r_prev;
    logic [CNT_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [DC_W-1:0]      r_div_cnt;
    logic                 r_out_valid;
    t_result              r_out;

    logic [TIME_BITS-1:0] now_in;
    logic [MW-1:0]        rd_data;
    logic [SEQ_W-1:0]     rd_seq;
    logic [TIME_BITS-1:0] rd_time;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [MW-1:0]        mem_wdata;
    logic [CNT_W-1:0]     up_src;
    logic [CNT_W-1:0]     dn_dst;
    logic [SEQ_W-1:0]     key_next;
    logic                 q_new_run;
    logic [CNT_W-1:0]     q_len_n;
    logic [CNT_W:0]       div_shift;
    logic [CNT_W:0]       div_diff;
    logic                 div_ge;

    // Time stamps are kept at TIME_BITS bits.
    generate
        if (TIME_BITS <= NOW_W) begin : g_now_cut
            assign now_in = i_item.now_time[TIME_BITS-1:0];
        end else begin : g_now_ext
            assign now_in = {{(TIME_BITS-NOW_W){1'b0}}, i_item.now_time};
        end
    endgenerate

    // An entry has expired when its time plus the window is at or before now.
    function automatic logic expired(input logic [TIME_BITS-1:0] t,
                                     input logic [WIN_W-1:0] win,
                                     input logic [TIME_BITS-1:0] now);
        logic [SUM_W-1:0] s;
        s = SUM_W'(t) + SUM_W'(win);
        return s <= SUM_W'(now);
    endfunction

    assign rd_seq  = rd_data[MW-1:TIME_BITS];
    assign rd_time = rd_data[TIME_BITS-1:0];
    assign up_src  = r_ptr - ONE_C;
    assign dn_dst  = r_ptr - r_off;
    assign key_next = r_key + 32'd1;

    // Run detection for the query walk.
    assign q_new_run = (r_ptr == '0) || (rd_seq != (r_prev + 32'd1));
    assign q_len_n   = q_new_run ? ONE_C : (r_len + ONE_C);

    // One restoring division step: lost count over run count.
    assign div_shift = {r_rem, r_quo[CNT_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_runs};
    assign div_diff  = div_shift - {1'b0, r_runs};

    // Memory port control follows the walk state.
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_ptr[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_ptr[AW-1:0];
        mem_wdata = rd_data;
        case (r_state)
            S_FIND_RD, S_DN_RD, S_AGE_RD, S_CNT_RD, S_Q_RD: begin
                mem_re = (r_ptr != r_count);
            end
            S_UP_RD: begin
                if (r_ptr == r_pos) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = {r_key, r_now};
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = up_src[AW-1:0];
                end
            end
            S_UP_WR: begin
                mem_we = 1'b1;
            end
            S_DN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = dn_dst[AW-1:0];
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    lst_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (MW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // Window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op  <= i_item.command;
                        r_key <= i_item.seq_num;
                        r_end <= i_item.range_end;
                        r_now <= now_in;
                        r_ovf <= 1'b0;
                        r_ptr <= '0;
                        case (i_item.command)
                            CMD_ADD_ONE, CMD_REMOVE: begin
                                r_state <= S_FIND_RD;
                            end
                            CMD_ADD_RANGE: begin
                                r_present <= '0;
                                if (i_item.seq_num >= i_item.range_end) begin
                                    r_state <= S_AGE;
                                end else if (r_count >= DEPTH_C) begin
                                    r_state <= S_CNT_RD;
                                end else begin
                                    r_state <= S_FIND_RD;
                                end
                            end
                            CMD_AGE_ONLY: begin
                                r_state <= S_AGE;
                            end
                            CMD_QUERY: begin
                                r_runs    <= '0;
                                r_len     <= '0;
                                r_longest <= '0;
                                r_state   <= S_Q_RD;
                            end
                            default: begin
                                // Unknown code: report the count, leave the table alone.
                                r_out_valid           <= 1'b1;
                                r_out.overflow        <= 1'b0;
                                r_out.lost_total      <= OUT_W'(r_count);
                                r_out.longest_run     <= '0;
                                r_out.mean_run        <= '0;
                            end
                        endcase
                    end
                end

                // Walk to the first entry at or above the key.
                S_FIND_RD: begin
                    if (r_ptr == r_count) begin
                        r_pos   <= r_count;
                        r_match <= 1'b0;
                        r_state <= S_FOUND;
                    end else begin
                        r_state <= S_FIND_CK;
                    end
                end
                S_FIND_CK: begin
                    if (rd_seq >= r_key) begin
                        r_pos   <= r_ptr;
                        r_match <= (rd_seq == r_key);
                        r_state <= S_FOUND;
                    end else begin
                        r_ptr   <= r_ptr + ONE_C;
                        r_state <= S_FIND_RD;
                    end
                end
                S_FOUND: begin
                    if (r_op == CMD_REMOVE) begin
                        if (r_match) begin
                            r_ptr   <= r_pos + ONE_C;
                            r_off   <= ONE_C;
                            r_state <= S_DN_RD;
                        end else begin
                            r_state <= S_AGE;
                        end
                    end else if (r_match) begin
                        r_state <= S_INS_DONE;
                    end else if (r_count >= DEPTH_C) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_AGE;
                    end else begin
                        if (r_count == '0) begin
                            r_oldest <= r_now;
                        end
                        r_ptr   <= r_count;
                        r_state <= S_UP_RD;
                    end
                end

                // Open a slot by moving the tail up one entry, top first.
                S_UP_RD: begin
                    if (r_ptr == r_pos) begin
                        r_count <= r_count + ONE_C;
                        r_state <= S_INS_DONE;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    r_ptr   <= up_src;
                    r_state <= S_UP_RD;
                end

                // Next number of a range, or the count of what is left over.
                S_INS_DONE: begin
                    if (r_op == CMD_ADD_ONE || key_next == r_end) begin
                        r_state <= S_AGE;
                    end else begin
                        r_key <= key_next;
                        if (r_count < DEPTH_C) begin
                            r_ptr   <= r_pos;
                            r_state <= S_FIND_RD;
                        end else begin
                            r_ptr     <= '0;
                            r_present <= '0;
                            r_state   <= S_CNT_RD;
                        end
                    end
                end
                S_CNT_RD: begin
                    if (r_ptr == r_count) begin
                        r_ovf   <= ((r_end - r_key) > SEQ_W'(r_present));
                        r_state <= S_AGE;
                    end else begin
                        r_state <= S_CNT_CK;
                    end
                end
                S_CNT_CK: begin
                    if (rd_seq >= r_key && rd_seq < r_end) begin
                        r_present <= r_present + ONE_C;
                    end
                    r_ptr   <= r_ptr + ONE_C;
                    r_state <= S_CNT_RD;
                end

                // Close a gap of r_off entries by moving the tail down.
                S_DN_RD: begin
                    if (r_ptr == r_count) begin
                        r_count <= r_count - r_off;
                        r_state <= (r_op == CMD_REMOVE) ? S_AGE : S_FINISH;
                        r_op    <= CMD_AGE_ONLY;
                    end else begin
                        r_state <= S_DN_WR;
                    end
                end
                S_DN_WR: begin
                    r_ptr   <= r_ptr + ONE_C;
                    r_state <= S_DN_RD;
                end

                // Aging: drop the expired prefix in sequence order.
                S_AGE: begin
                    r_ptr <= '0;
                    if (expired(r_oldest, r_window, r_now)) begin
                        r_state <= S_AGE_RD;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_AGE_RD: begin
                    if (r_ptr == r_count) begin
                        r_count <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_AGE_CK;
                    end
                end
                S_AGE_CK: begin
                    if (expired(rd_time, r_window, r_now)) begin
                        r_ptr   <= r_ptr + ONE_C;
                        r_state <= S_AGE_RD;
                    end else begin
                        r_oldest <= rd_time;
                        if (r_ptr == '0) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_off   <= r_ptr;
                            r_op    <= CMD_AGE_ONLY;
                            r_state <= S_DN_RD;
                        end
                    end
                end

                // Query: count runs and the longest one, then divide for the mean run length.
                S_Q_RD: begin
                    if (r_ptr == r_count) begin
                        r_quo     <= r_count;
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= (r_runs == '0) ? S_FINISH : S_DIV;
                    end else begin
                        r_state <= S_Q_CK;
                    end
                end
                S_Q_CK: begin
                    r_len  <= q_len_n;
                    r_prev <= rd_seq;
                    if (q_new_run) begin
                        r_runs <= r_runs + ONE_C;
                    end
                    if (q_len_n > r_longest) begin
                        r_longest <= q_len_n;
                    end
                    r_ptr   <= r_ptr + ONE_C;
                    r_state <= S_Q_RD;
                end
                S_DIV: begin
                    r_rem     <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
                    r_quo     <= {r_quo[CNT_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt + DC_W'(1);
                    if (r_div_cnt == DC_W'(CNT_W - 1)) begin
                        r_state <= S_FINISH;
                    end
                end

                // Present the result word for one cycle.
                S_FINISH: begin
                    r_out_valid       <= 1'b1;
                    r_out.overflow    <= r_ovf;
                    r_out.lost_total  <= OUT_W'(r_count);
                    r_out.longest_run <= (r_op == CMD_QUERY) ? OUT_W'(r_longest) : '0;
                    r_out.mean_run    <= (r_op == CMD_QUERY && r_runs != '0) ?
                                         OUT_W'(r_quo) : '0;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above table depth");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD) |-> (r_count < DEPTH_C))
        else $error("insert shift started on a full table");

    a_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (AW'(mem_waddr) < AW'(TABLE_DEPTH - 1) || mem_waddr == AW'(TABLE_DEPTH - 1)))
        else $error("table write beyond depth");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.command == CMD_QUERY) |=> busy)
        else $error("query accepted without starting the walk");
`endif

endmodule

`default_nettype wire

@@ design/lst_ram.sv @@
// Single-port-write, single-port-read table memory for the tracker.
// Read data is registered.
// No dependencies.
`default_nettype none

module lst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 80
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
